### design/p2fd_pkg.sv
// Shared widths, constants, types and the seven-segment encoder of the period-to-frequency display.
package p2fd_pkg;

    // Default display size in decimal digits
    localparam int P2FD_NUM_DIGITS = 4;

    // Field widths
    localparam int PERIOD_W = 16;
    localparam int TPS_W    = 24;
    localparam int FREQ_W   = 24;
    localparam int SEG_W    = 7;

    // Positions that leave the block: thousands, hundreds, tens, units
    localparam int SHOWN_DIGITS = 4;

    // Ticks-per-second register after reset
    localparam logic [TPS_W-1:0] TPS_RESET = 24'd1000000;

    // Divide by ten as multiply by ceil(2^30 / 10); exact for values below 2^27
    localparam int          DIV10_SHIFT = 30;
    localparam int          DIV10_K_W   = 27;
    localparam logic [26:0] DIV10_K     = 27'd107374183;

    typedef logic [SEG_W-1:0] t_seg;

    // Quotient and divide-by-zero flag from the divider to the digit splitter
    typedef struct packed {
        logic              zero;
        logic [FREQ_W-1:0] quotient;
    } t_div_result;

    // Segment patterns for digits 0 to 9, bit 6 = a .. bit 0 = g
    localparam t_seg SEG_0 = 7'b1111110;
    localparam t_seg SEG_1 = 7'b0110000;
    localparam t_seg SEG_2 = 7'b1101101;
    localparam t_seg SEG_3 = 7'b1111001;
    localparam t_seg SEG_4 = 7'b0110011;
    localparam t_seg SEG_5 = 7'b1011011;
    localparam t_seg SEG_6 = 7'b1011111;
    localparam t_seg SEG_7 = 7'b1110000;
    localparam t_seg SEG_8 = 7'b1111111;
    localparam t_seg SEG_9 = 7'b1111011;
    localparam t_seg SEG_BLANK = 7'b0000000;

    function automatic t_seg seg_encode(input logic [3:0] digit);
        t_seg pattern;
        case (digit)
            4'd0: pattern = SEG_0;
            4'd1: pattern = SEG_1;
            4'd2: pattern = SEG_2;
            4'd3: pattern = SEG_3;
            4'd4: pattern = SEG_4;
            4'd5: pattern = SEG_5;
            4'd6: pattern = SEG_6;
            4'd7: pattern = SEG_7;
            4'd8: pattern = SEG_8;
            4'd9: pattern = SEG_9;
            default: pattern = SEG_BLANK;
        endcase
        return pattern;
    endfunction

endpackage

### design/p2fd_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module p2fd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [p2fd_pkg::TPS_W-1:0]     i_dividend,
    input  logic [p2fd_pkg::PERIOD_W-1:0]  i_divisor,
    output logic                           o_valid,
    input  logic                           i_ready,
    output p2fd_pkg::t_div_result          o_result
);
    import p2fd_pkg::*;

    localparam int STAGES = TPS_W;

    logic                r_vld [STAGES];
    logic [PERIOD_W-1:0] r_rem [STAGES];
    logic [PERIOD_W-1:0] r_dvs [STAGES];
    logic [TPS_W-1:0]    r_nq  [STAGES];
    logic                stage_rdy [STAGES+1];

    // A stage takes a beat when it is empty or its content moves on
    assign stage_rdy[STAGES] = i_ready;
    assign o_ready           = stage_rdy[0];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                src_vld;
        logic [PERIOD_W-1:0] src_rem;
        logic [PERIOD_W-1:0] src_dvs;
        logic [TPS_W-1:0]    src_nq;
        logic [PERIOD_W:0]   trial;
        logic [PERIOD_W:0]   diff;
        logic                ge;
        logic [PERIOD_W-1:0] n_rem;
        logic [TPS_W-1:0]    n_nq;

        if (k == 0) begin : g_first
            assign src_vld = i_valid;
            assign src_rem = '0;
            assign src_dvs = i_divisor;
            assign src_nq  = i_dividend;
        end else begin : g_next
            assign src_vld = r_vld[k-1];
            assign src_rem = r_rem[k-1];
            assign src_dvs = r_dvs[k-1];
            assign src_nq  = r_nq[k-1];
        end

        assign stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];

        // Bring down the next dividend bit, subtract the divisor if it fits
        assign trial = {src_rem, src_nq[TPS_W-1]};
        assign ge    = trial >= {1'b0, src_dvs};
        assign diff  = trial - {1'b0, src_dvs};
        assign n_rem = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        assign n_nq  = {src_nq[TPS_W-2:0], ge};

        // Valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (stage_rdy[k]) begin
                r_vld[k] <= src_vld;
            end
        end

        // Partial remainder, shifting dividend/quotient word and divisor
        always_ff @(posedge i_clk) begin
            if (stage_rdy[k]) begin
                r_rem[k] <= n_rem;
                r_nq[k]  <= n_nq;
                r_dvs[k] <= src_dvs;
            end
        end
    end

    assign o_valid           = r_vld[STAGES-1];
    assign o_result.zero     = (r_dvs[STAGES-1] == '0);
    assign o_result.quotient = r_nq[STAGES-1];

endmodule

### design/p2fd_digits.sv
// Saturation, decimal digit split and seven-segment encoding, one digit per stage.
module p2fd_digits #(
    parameter int NUM_DIGITS = p2fd_pkg::P2FD_NUM_DIGITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  p2fd_pkg::t_div_result                        i_result,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic [p2fd_pkg::FREQ_W-1:0]                  o_frequency,
    output p2fd_pkg::t_seg [p2fd_pkg::SHOWN_DIGITS-1:0]  o_segs,
    output logic                                         o_over,
    output logic                                         o_zero
);
    import p2fd_pkg::*;

    localparam logic [31:0] LIMIT  = 32'(10 ** NUM_DIGITS) - 32'd1;
    localparam int          VAL_W  = $clog2(10 ** NUM_DIGITS);
    localparam int          PROD_W = VAL_W + DIV10_SHIFT;
    // Saturate, one divide per digit, last digit encode
    localparam int          STAGES = SHOWN_DIGITS + 2;

    function automatic logic [VAL_W-1:0] div10(input logic [VAL_W-1:0] v);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v) * PROD_W'(DIV10_K);
        return prod[DIV10_SHIFT +: VAL_W];
    endfunction

    logic              r_vld   [STAGES];
    logic [FREQ_W-1:0] r_freq  [STAGES];
    logic              r_zero  [STAGES];
    logic              r_over  [STAGES];
    logic [VAL_W-1:0]  r_cur   [0:SHOWN_DIGITS];
    logic [VAL_W-1:0]  r_quo   [1:SHOWN_DIGITS];
    t_seg [SHOWN_DIGITS-1:0] r_seg [2:STAGES-1];
    logic              stage_rdy [STAGES+1];

    logic [31:0]       sat_val;
    logic              sat_over;

    assign stage_rdy[STAGES] = i_ready;
    assign o_ready           = stage_rdy[0];

    for (genvar k = 0; k < STAGES; k++) begin : g_ctl
        logic src_vld;
        if (k == 0) begin : g_first
            assign src_vld = i_valid;
        end else begin : g_next
            assign src_vld = r_vld[k-1];
        end

        assign stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];

        // Valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (stage_rdy[k]) begin
                r_vld[k] <= src_vld;
            end
        end

        // Carry quotient and flags alongside
        if (k > 0) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (stage_rdy[k]) begin
                    r_freq[k] <= r_freq[k-1];
                    r_zero[k] <= r_zero[k-1];
                    r_over[k] <= r_over[k-1];
                end
            end
        end
    end

    // Clamp the quotient to the largest value the display shows
    assign sat_over = !i_result.zero && ({8'b0, i_result.quotient} > LIMIT);
    assign sat_val  = i_result.zero ? 32'd0 :
                      sat_over      ? LIMIT : {8'b0, i_result.quotient};

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_freq[0] <= i_result.zero ? '0 : i_result.quotient;
            r_zero[0] <= i_result.zero;
            r_over[0] <= sat_over;
            r_cur[0]  <= sat_val[VAL_W-1:0];
        end
    end

    // Divide by ten, one position per stage
    for (genvar j = 1; j <= SHOWN_DIGITS; j++) begin : g_div10
        logic [VAL_W-1:0] src;
        if (j == 1) begin : g_first
            assign src = r_cur[0];
        end else begin : g_next
            assign src = r_quo[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (stage_rdy[j]) begin
                r_cur[j] <= src;
                r_quo[j] <= div10(src);
            end
        end
    end

    // Take the remainder of the previous stage and encode it
    for (genvar j = 2; j < STAGES; j++) begin : g_enc
        localparam int POS = j - 2;
        logic [VAL_W-1:0]        rem;
        t_seg                    pattern;
        t_seg [SHOWN_DIGITS-1:0] prev;

        // Patterns already encoded for this beat; blank before the first position
        if (j == 2) begin : g_first
            assign prev = {SHOWN_DIGITS{SEG_BLANK}};
        end else begin : g_next
            assign prev = r_seg[j-1];
        end

        assign rem = r_cur[j-1] - {r_quo[j-1][VAL_W-4:0], 3'b000}
                                - {r_quo[j-1][VAL_W-2:0], 1'b0};
        assign pattern = (POS < NUM_DIGITS && !r_zero[j-1]) ? seg_encode(rem[3:0])
                                                            : SEG_BLANK;

        always_ff @(posedge i_clk) begin
            if (stage_rdy[j]) begin
                for (int p = 0; p < SHOWN_DIGITS; p++) begin
                    if (p == POS) begin
                        r_seg[j][p] <= pattern;
                    end else begin
                        r_seg[j][p] <= prev[p];
                    end
                end
            end
        end
    end

    assign o_valid     = r_vld[STAGES-1];
    assign o_frequency = r_freq[STAGES-1];
    assign o_segs      = r_seg[STAGES-1];
    assign o_over      = r_over[STAGES-1];
    assign o_zero      = r_zero[STAGES-1];

endmodule

### design/period_to_frequency_display_unit.sv
// Top level: period in timer ticks to frequency and four seven-segment digits.
//
//   channel   direction  handshake            payload
//   period    in         i_valid / o_ready    i_period_ticks
//   result    out        o_valid / i_ready    o_frequency, o_seg_*, o_over_range, o_zero_period
//   config    in         i_cfg_we             i_cfg_wdata (ticks per second)
//
// The path runs through 24 divider stages, one quotient bit each, then one
// saturation stage, four divide-by-ten stages and the final encode stage.
// One period is taken every cycle while the result side keeps up.
// Each stage holds its beat while the next is full and stalled; empty stages fill.
// Synchronous active-low reset clears all valid bits and loads 1000000 ticks per second.
module period_to_frequency_display_unit #(
    parameter int NUM_DIGITS = p2fd_pkg::P2FD_NUM_DIGITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [p2fd_pkg::PERIOD_W-1:0]  i_period_ticks,
    input  logic                           i_cfg_we,
    input  logic [p2fd_pkg::TPS_W-1:0]     i_cfg_wdata,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [p2fd_pkg::FREQ_W-1:0]    o_frequency,
    output logic [p2fd_pkg::SEG_W-1:0]     o_seg_thousands,
    output logic [p2fd_pkg::SEG_W-1:0]     o_seg_hundreds,
    output logic [p2fd_pkg::SEG_W-1:0]     o_seg_tens,
    output logic [p2fd_pkg::SEG_W-1:0]     o_seg_units,
    output logic                           o_over_range,
    output logic                           o_zero_period
);
    import p2fd_pkg::*;

    logic [TPS_W-1:0]        r_ticks_per_second;
    logic                    div_valid;
    logic                    div_ready;
    t_div_result             div_result;
    t_seg [SHOWN_DIGITS-1:0] segs;

    // Ticks-per-second register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second <= TPS_RESET;
        end else if (i_cfg_we) begin
            r_ticks_per_second <= i_cfg_wdata;
        end
    end

    // Divide ticks per second by the period
    p2fd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_dividend (r_ticks_per_second),
        .i_divisor  (i_period_ticks),
        .o_valid    (div_valid),
        .i_ready    (div_ready),
        .o_result   (div_result)
    );

    // Saturate, split into digits and encode
    p2fd_digits #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_digits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .o_ready     (div_ready),
        .i_result    (div_result),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_frequency (o_frequency),
        .o_segs      (segs),
        .o_over      (o_over_range),
        .o_zero      (o_zero_period)
    );

    assign o_seg_units     = segs[0];
    assign o_seg_tens      = segs[1];
    assign o_seg_hundreds  = segs[2];
    assign o_seg_thousands = segs[3];

endmodule

### design/p2fd_checker.sv
// Port-level checks on the period-to-frequency display, bound to the top level.
module p2fd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [p2fd_pkg::FREQ_W-1:0]    o_frequency,
    input logic [p2fd_pkg::SEG_W-1:0]     o_seg_thousands,
    input logic [p2fd_pkg::SEG_W-1:0]     o_seg_hundreds,
    input logic [p2fd_pkg::SEG_W-1:0]     o_seg_tens,
    input logic [p2fd_pkg::SEG_W-1:0]     o_seg_units,
    input logic                           o_over_range,
    input logic                           o_zero_period
);
    import p2fd_pkg::*;

    // Drop every beat in flight on reset
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Blank display and zero frequency for a zero period
    a_zero_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_period |-> o_frequency == '0 && !o_over_range &&
            o_seg_thousands == SEG_BLANK && o_seg_hundreds == SEG_BLANK &&
            o_seg_tens == SEG_BLANK && o_seg_units == SEG_BLANK)
        else $error("zero period result not blank");

    // Saturated result shows nine in the units place and is not a zero period
    a_over_nines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_over_range |-> o_seg_units == SEG_9 && !o_zero_period &&
            o_frequency != '0)
        else $error("over-range result not saturated");

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frequency) &&
            $stable(o_seg_units))
        else $error("stalled result changed");

endmodule

bind period_to_frequency_display_unit p2fd_checker u_p2fd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_frequency     (o_frequency),
    .o_seg_thousands (o_seg_thousands),
    .o_seg_hundreds  (o_seg_hundreds),
    .o_seg_tens      (o_seg_tens),
    .o_seg_units     (o_seg_units),
    .o_over_range    (o_over_range),
    .o_zero_period   (o_zero_period)
);
